// ----- hw/rtl/u2l_pkg.sv -----
// Shared types and constants for the UTF-8 to Latin-1 stream decoder.
`timescale 1ns / 1ps

package u2l_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LIMIT_W    = 16;
   localparam int unsigned LEAD_W     = 5;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 16'd256;

   localparam logic [BYTE_W-1:0] SUB_CHAR  = 8'h3F;
   localparam logic [BYTE_W-1:0] TERM_CHAR = 8'h00;

   // decoder phases
   localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
   localparam logic [PHASE_W-1:0] PH_TWO  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_THR1 = 3'd2;
   localparam logic [PHASE_W-1:0] PH_THR2 = 3'd3;
   localparam logic [PHASE_W-1:0] PH_SKIP = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] out_char;
      logic              text_end;
      logic              last_in_run;
   } result_type;

   // what one decoded item leaves for the result queue
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } batch_type;

endpackage

// ----- hw/rtl/u2l_decoder.sv -----
// Per-byte decode logic and decoder state (phase, lead bits, emitted count).
`timescale 1ns / 1ps

module u2l_decoder
   import u2l_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [BYTE_W-1:0]   in_byte,
   input  logic [LIMIT_W-1:0]  out_limit,
   output batch_type           batch
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [LEAD_W-1:0]  lead_ff, lead_in;
   logic [LIMIT_W-1:0] count_ff, count_in;

   logic              is_zero, is_cont;
   logic              ld_emit, ld_set;
   logic [BYTE_W-1:0] ld_char;
   logic [PHASE_W-1:0] ld_phase;
   logic              ca_v, cb_v, use_lead;
   logic [BYTE_W-1:0] ca, cb;
   logic [LIMIT_W-1:0] cap, cnt1;
   logic              acc_a, acc_b;
   logic [PHASE_W-1:0] ph_next;

   assign is_zero = (in_byte == '0);
   assign is_cont = (in_byte[7:6] == 2'b10);
   assign cap     = (out_limit == '0) ? '0 : out_limit - LIMIT_W'(1);

   // lead byte classification
   always_comb begin
      ld_emit  = 1'b0;
      ld_set   = 1'b0;
      ld_char  = SUB_CHAR;
      ld_phase = PH_IDLE;
      if (!in_byte[7]) begin
         ld_emit = 1'b1;
         ld_char = in_byte;
      end else if (in_byte[7:5] == 3'b110) begin
         ld_set   = 1'b1;
         ld_phase = PH_TWO;
      end else if (in_byte[7:4] == 4'b1110) begin
         ld_phase = PH_THR1;
      end else begin
         ld_emit  = 1'b1;
         ld_phase = PH_SKIP;
      end
   end

   // up to two candidate characters, then the next phase
   always_comb begin
      ca_v     = 1'b0;
      ca       = SUB_CHAR;
      use_lead = 1'b0;
      ph_next  = phase_ff;
      if (is_zero) begin
         ca_v    = (phase_ff == PH_TWO) || (phase_ff == PH_THR1) || (phase_ff == PH_THR2);
         ph_next = PH_IDLE;
      end else begin
         case (phase_ff)
            PH_TWO: begin
               ca_v = 1'b1;
               if (is_cont) begin
                  ph_next = PH_IDLE;
                  if (lead_ff[4:2] == 3'b000) begin
                     ca = {lead_ff[1:0], in_byte[5:0]};
                  end
               end else begin
                  use_lead = 1'b1;
               end
            end
            PH_THR1: begin
               if (is_cont) begin
                  ph_next = PH_THR2;
               end else begin
                  ca_v     = 1'b1;
                  use_lead = 1'b1;
               end
            end
            PH_THR2: begin
               ca_v = 1'b1;
               if (is_cont) begin
                  ph_next = PH_IDLE;
               end else begin
                  use_lead = 1'b1;
               end
            end
            PH_SKIP: begin
               if (!is_cont) begin
                  use_lead = 1'b1;
               end
            end
            default: begin
               use_lead = 1'b1;
            end
         endcase
         if (use_lead) begin
            ph_next = ld_phase;
         end
      end
      cb_v = use_lead && ld_emit;
      cb   = ld_char;
   end

   // output limit, applied to each character in order
   assign acc_a = ca_v && (count_ff < cap);
   assign cnt1  = count_ff + LIMIT_W'(acc_a);
   assign acc_b = cb_v && (cnt1 < cap);

   always_comb begin
      result_type slot [2];
      logic [1:0] n;
      result_type term;
      n = 2'd0;
      slot[0] = '{out_char: SUB_CHAR, text_end: 1'b0, last_in_run: 1'b0};
      slot[1] = slot[0];
      term    = '{out_char: TERM_CHAR, text_end: 1'b1, last_in_run: 1'b0};
      if (acc_a) begin
         slot[0].out_char = ca;
         n = 2'd1;
      end
      if (acc_b) begin
         slot[n[0]].out_char = cb;
         n = n + 2'd1;
      end
      if (is_zero) begin
         slot[n[0]] = term;
         n = n + 2'd1;
      end
      if (n == 2'd1) begin
         slot[0].last_in_run = 1'b1;
      end else if (n == 2'd2) begin
         slot[1].last_in_run = 1'b1;
      end
      batch.count = n;
      batch.res0  = slot[0];
      batch.res1  = slot[1];
   end

   always_comb begin
      phase_in = phase_ff;
      lead_in  = lead_ff;
      count_in = count_ff;
      if (fire) begin
         phase_in = ph_next;
         if (is_zero) begin
            lead_in  = '0;
            count_in = '0;
         end else begin
            count_in = cnt1 + LIMIT_W'(acc_b);
            if (use_lead && ld_set) begin
               lead_in = in_byte[LEAD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         lead_ff  <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         lead_ff  <= lead_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/u2l_result_queue.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module u2l_result_queue
   import u2l_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  batch_type  batch,
   input  logic       pop,
   output logic       not_empty,
   output logic       has_room,
   output result_type head
);

   result_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CW-1:0]  cnt_ff, cnt_in;
   logic [1:0]          n_push;
   logic                do_pop;

   assign not_empty = (cnt_ff != '0);
   // room for a full batch regardless of the pop this cycle
   assign has_room  = (cnt_ff <= FIFO_CW'(FIFO_DEPTH - 2));
   assign head      = mem_ff[rd_ff];
   assign do_pop    = pop && not_empty;
   assign n_push    = push ? batch.count : 2'd0;

   always_comb begin
      wr_in  = wr_ff + FIFO_AW'(n_push);
      rd_in  = rd_ff + FIFO_AW'(do_pop);
      cnt_in = cnt_ff + FIFO_CW'(n_push) - FIFO_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ff] <= batch.res0;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ff + FIFO_AW'(1)] <= batch.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/utf8_to_latin1_stream_decoder_unit.sv -----
// Top level of the UTF-8 to Latin-1 stream decoder.
// Path: an item is registered at acceptance in the input register, decoded once the
//   result queue has room for a full batch, and written into the queue; its first
//   result shows on rsp_ from the queue head.
// Throughput: one item per cycle while the queue has room; results leave one at a time,
//   so the output sets the sustained rate to one result per cycle when not stalled.
// Reset (synchronous, active high): decoder idle, counters cleared, queue empty,
//   out_limit back to LIMIT_RESET (default 256).
`timescale 1ns / 1ps

module utf8_to_latin1_stream_decoder_unit
   import u2l_pkg::*;
#(
   parameter logic [LIMIT_W-1:0] LIMIT_RESET = OUT_LIMIT_RESET
) (
   input  logic               clock,
   input  logic               reset,
   // input byte channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_in_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_out_char,
   output logic               rsp_text_end,
   output logic               rsp_last_in_run,
   // out_limit register
   input  logic               csr_write,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff, in_byte_in;
   logic               req_take, fire, has_room;
   batch_type          batch;
   result_type         head;

   // config register, only written while the block is idle: the user must keep to this, the block does not enforce it
   assign limit_in = csr_write ? csr_wdata : limit_ff;

   // input register: decode fires when the queue can take a full batch
   assign fire      = in_valid_ff && has_room;
   assign req_stall = in_valid_ff && !has_room;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         in_valid_ff <= in_valid_in;
      end
   end

   u2l_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .in_byte   (in_byte_ff),
      .out_limit (limit_ff),
      .batch     (batch)
   );

   u2l_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .batch     (batch),
      .pop       (!rsp_stall),
      .not_empty (rsp_valid),
      .has_room  (has_room),
      .head      (head)
   );

   assign rsp_out_char    = head.out_char;
   assign rsp_text_end    = head.text_end;
   assign rsp_last_in_run = head.last_in_run;

endmodule
